// ===== hw/rtl/bre_pkg.sv =====
package bre_pkg;

    // field widths
    localparam int ANG_W  = 16;
    localparam int RATE_W = 16;
    localparam int OUT_W  = 24;

    // CORDIC
    localparam int STEPS  = 24;
    localparam int XY_W   = 34;
    localparam int CS_W   = 18;
    localparam int CORDIC_LAT = STEPS + 1;
    localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
    localparam logic signed [16:0] PI_Q13      = 17'sd25736;
    localparam logic signed [CS_W-1:0] COS_MIN = 18'sd256;

    // divider
    localparam int DIV_NW = 35;
    localparam int DIV_DW = 18;
    localparam int DIV_QW = 27;

    // output limits
    localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

    // queue
    localparam int QDEPTH_DEF = 4;

    // one folded item held in the queue
    typedef struct packed {
        logic signed [ANG_W-1:0]  roll_a;
        logic                     roll_neg;
        logic signed [ANG_W-1:0]  pitch_a;
        logic                     pitch_neg;
        logic signed [RATE_W-1:0] p;
        logic signed [RATE_W-1:0] q;
        logic signed [RATE_W-1:0] r;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Q30 arctangent table, truncated toward zero
    function automatic logic signed [XY_W-1:0] atan_q30(input int i);
        logic signed [XY_W-1:0] v;
        case (i)
            0:  v = 34'sh03243F6A8;
            1:  v = 34'sh01DAC6705;
            2:  v = 34'sh00FADBAFC;
            3:  v = 34'sh007F56EA6;
            4:  v = 34'sh003FEAB76;
            5:  v = 34'sh001FFD55B;
            6:  v = 34'sh000FFFAAA;
            7:  v = 34'sh0007FFF55;
            8:  v = 34'sh0003FFFEA;
            9:  v = 34'sh0001FFFFD;
            10: v = 34'sh0000FFFFF;
            11: v = 34'sh00007FFFF;
            12: v = 34'sh00003FFFF;
            13: v = 34'sh00001FFFF;
            14: v = 34'sh00000FFFF;
            15: v = 34'sh000007FFF;
            16: v = 34'sh000003FFF;
            17: v = 34'sh000001FFF;
            18: v = 34'sh000000FFF;
            19: v = 34'sh0000007FF;
            20: v = 34'sh0000003FF;
            21: v = 34'sh0000001FF;
            22: v = 34'sh0000000FF;
            23: v = 34'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    // clamp to 24 bits; top bit of the result is the saturation flag
    function automatic logic [OUT_W:0] sat24(input logic signed [29:0] v);
        logic [OUT_W:0] res;
        if (v > 30'(OUT_MAX)) begin
            res = {1'b1, OUT_MAX};
        end else if (v < 30'(OUT_MIN)) begin
            res = {1'b1, OUT_MIN};
        end else begin
            res = {1'b0, v[OUT_W-1:0]};
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/bre_front.sv =====
module bre_front (
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [bre_pkg::ANG_W-1:0]  i_roll_angle,
    input  logic signed [bre_pkg::ANG_W-1:0]  i_pitch_angle,
    input  logic signed [bre_pkg::RATE_W-1:0] i_rate_x,
    input  logic signed [bre_pkg::RATE_W-1:0] i_rate_y,
    input  logic signed [bre_pkg::RATE_W-1:0] i_rate_z,
    input  bre_pkg::t_qstat                   i_qstat,
    output logic                              o_push,
    output bre_pkg::t_item                    o_item
);

    // fold an angle into [-pi/2, pi/2], flagging a negated cosine
    function automatic logic [bre_pkg::ANG_W:0] fold(input logic signed [bre_pkg::ANG_W-1:0] a);
        logic signed [16:0] a17;
        logic signed [16:0] f;
        logic               neg;
        a17 = 17'(a);
        if (a17 > bre_pkg::HALF_PI_Q13) begin
            f   = bre_pkg::PI_Q13 - a17;
            neg = 1'b1;
        end else if (a17 < -bre_pkg::HALF_PI_Q13) begin
            f   = -bre_pkg::PI_Q13 - a17;
            neg = 1'b1;
        end else begin
            f   = a17;
            neg = 1'b0;
        end
        return {neg, f[bre_pkg::ANG_W-1:0]};
    endfunction

    logic [bre_pkg::ANG_W:0] roll_f;
    logic [bre_pkg::ANG_W:0] pitch_f;

    assign roll_f  = fold(i_roll_angle);
    assign pitch_f = fold(i_pitch_angle);

    // transfer into the queue whenever it has room
    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;

    always_comb begin
        o_item.roll_a    = roll_f[bre_pkg::ANG_W-1:0];
        o_item.roll_neg  = roll_f[bre_pkg::ANG_W];
        o_item.pitch_a   = pitch_f[bre_pkg::ANG_W-1:0];
        o_item.pitch_neg = pitch_f[bre_pkg::ANG_W];
        o_item.p         = i_rate_x;
        o_item.q         = i_rate_y;
        o_item.r         = i_rate_z;
    end

endmodule

// ===== hw/rtl/bre_fifo.sv =====
module bre_fifo #(
    parameter int DEPTH = bre_pkg::QDEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bre_pkg::t_item  i_item,
    input  logic            i_pop,
    output bre_pkg::t_item  o_item,
    output bre_pkg::t_qstat o_qstat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bre_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]  r_wr, n_wr;
    logic [AW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_cnt, n_cnt;

    // pointer wrap at any depth
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item        = r_mem[r_rd];
    assign o_qstat.full  = (r_cnt == CW'(DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

endmodule

// ===== hw/rtl/bre_cordic.sv =====
module bre_cordic (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [bre_pkg::ANG_W-1:0] i_angle,
    input  logic                             i_neg,
    output logic signed [bre_pkg::CS_W-1:0]  o_sin,
    output logic signed [bre_pkg::CS_W-1:0]  o_cos
);

    localparam int N = bre_pkg::STEPS;
    localparam int W = bre_pkg::XY_W;

    logic signed [W-1:0] x_in [N];
    logic signed [W-1:0] y_in [N];
    logic signed [W-1:0] z_in [N];
    logic signed [W-1:0] r_x  [N];
    logic signed [W-1:0] r_y  [N];
    logic signed [W-1:0] r_z  [N];
    logic                r_neg [N];

    logic signed [W-1:0] y_rnd;
    logic signed [W-1:0] x_rnd;
    logic signed [W-1:0] y_sh;
    logic signed [W-1:0] x_sh;

    logic signed [bre_pkg::CS_W-1:0] r_sin;
    logic signed [bre_pkg::CS_W-1:0] r_cos;

    // one rotation per stage
    for (genvar i = 0; i < N; i++) begin : g_stage
        if (i == 0) begin : g_first
            assign x_in[i] = bre_pkg::GAIN_Q30;
            assign y_in[i] = '0;
            assign z_in[i] = {i_angle[bre_pkg::ANG_W-1], i_angle, 17'd0};
        end else begin : g_next
            assign x_in[i] = r_x[i-1];
            assign y_in[i] = r_y[i-1];
            assign z_in[i] = r_z[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (z_in[i] >= 0) begin
                    r_x[i] <= x_in[i] - (y_in[i] >>> i);
                    r_y[i] <= y_in[i] + (x_in[i] >>> i);
                    r_z[i] <= z_in[i] - bre_pkg::atan_q30(i);
                end else begin
                    r_x[i] <= x_in[i] + (y_in[i] >>> i);
                    r_y[i] <= y_in[i] - (x_in[i] >>> i);
                    r_z[i] <= z_in[i] + bre_pkg::atan_q30(i);
                end
                r_neg[i] <= (i == 0) ? i_neg : r_neg[(i == 0) ? 0 : i-1];
            end
        end
    end

    // round Q30 down to Q16
    assign y_rnd = r_y[N-1] + W'(8192);
    assign x_rnd = r_x[N-1] + W'(8192);
    assign y_sh  = y_rnd >>> 14;
    assign x_sh  = x_rnd >>> 14;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= y_sh[bre_pkg::CS_W-1:0];
            r_cos <= r_neg[N-1] ? -x_sh[bre_pkg::CS_W-1:0] : x_sh[bre_pkg::CS_W-1:0];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ===== hw/rtl/bre_div.sv =====
module bre_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [bre_pkg::DIV_NW-1:0]  i_num,
    input  logic [bre_pkg::DIV_DW-1:0]  i_den,
    output logic [bre_pkg::DIV_QW-1:0]  o_quo
);

    localparam int NW = bre_pkg::DIV_NW;
    localparam int DW = bre_pkg::DIV_DW;
    localparam int QW = bre_pkg::DIV_QW;
    localparam int CW = DW + QW;

    logic [NW-1:0] rem_in [QW];
    logic [QW-1:0] quo_in [QW];
    logic [DW-1:0] den_in [QW];
    logic [NW-1:0] r_rem  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [DW-1:0] r_den  [QW];

    // restoring division, one quotient bit per stage, msb first
    for (genvar j = 0; j < QW; j++) begin : g_bit
        logic [CW-1:0] dsh;
        logic          ge;

        if (j == 0) begin : g_first
            assign rem_in[j] = i_num;
            assign quo_in[j] = '0;
            assign den_in[j] = i_den;
        end else begin : g_next
            assign rem_in[j] = r_rem[j-1];
            assign quo_in[j] = r_quo[j-1];
            assign den_in[j] = r_den[j-1];
        end

        assign dsh = CW'(den_in[j]) << (QW - 1 - j);
        assign ge  = (CW'(rem_in[j]) >= dsh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? NW'(CW'(rem_in[j]) - dsh) : rem_in[j];
                r_quo[j] <= quo_in[j] | (QW'(ge) << (QW - 1 - j));
                r_den[j] <= den_in[j];
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

// ===== hw/rtl/bre_back.sv =====
module bre_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bre_pkg::t_item                      i_item,
    input  bre_pkg::t_qstat                     i_qstat,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [bre_pkg::OUT_W-1:0]    o_roll_rate,
    output logic signed [bre_pkg::OUT_W-1:0]    o_pitch_rate,
    output logic signed [bre_pkg::OUT_W-1:0]    o_yaw_rate,
    output logic                                o_singular
);

    localparam int CL = bre_pkg::CORDIC_LAT;
    localparam int DL = bre_pkg::DIV_QW;
    localparam int RW = bre_pkg::RATE_W;
    localparam int SW = bre_pkg::CS_W;

    // fields that ride alongside the dividers
    typedef struct packed {
        logic signed [RW-1:0]               p;
        logic signed [bre_pkg::OUT_W-1:0]   pitch;
        logic                               w_zero;
        logic                               pos;
        logic                               s_neg;
        logic                               sing;
        logic                               yaw_neg;
        logic                               roll_neg;
    } t_side;

    logic en;

    logic signed [SW-1:0] s_phi, c_phi, s_th, c_th;

    logic                 r_v1 [CL];
    logic signed [RW-1:0] r_p1 [CL];
    logic signed [RW-1:0] r_q1 [CL];
    logic signed [RW-1:0] r_r1 [CL];

    logic                 r_m1_v, r_m2_v, r_m3_v, r_m4_v;
    logic signed [33:0]   r_sq, r_cr, r_cq, r_sr;
    logic signed [RW-1:0] r_m1_p, r_m2_p, r_m3_p;
    logic signed [SW-1:0] r_m1_s, r_m1_c, r_m2_s, r_m2_c, r_m3_s, r_m3_c;
    logic signed [34:0]   r_w, r_v, r_m3_w;
    logic signed [52:0]   r_prod;
    logic signed [bre_pkg::OUT_W-1:0] r_m3_pitch;

    logic [34:0]          abs_v;
    logic [18:0]          pr_mag;
    logic [SW-1:0]        abs_c;
    logic [34:0]          abs_w;
    logic [52:0]          abs_prod;
    logic [53:0]          rsum;

    logic [bre_pkg::DIV_NW-1:0] r_ynum, r_rnum;
    logic [bre_pkg::DIV_DW-1:0] r_den;
    t_side                      r_m4_sd;
    t_side                      m4_sd;

    logic  r_v2 [DL];
    t_side r_sd [DL];

    logic [bre_pkg::DIV_QW-1:0] q_yaw, q_roll;
    t_side                      sd;
    logic signed [29:0]         yaw_full, tan_full, roll_full;
    logic [bre_pkg::OUT_W:0]    yaw_sat, roll_sat;
    logic signed [bre_pkg::OUT_W-1:0] n_roll, n_yaw;
    logic                       n_flag;
    logic                       r_out_valid;

    logic signed [bre_pkg::OUT_W-1:0] r_roll_rate, r_pitch_rate, r_yaw_rate;
    logic                             r_singular;

    // whole pipeline moves unless the output register is held
    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && !i_qstat.empty;

    bre_cordic u_cordic_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_item.roll_a),
        .i_neg   (i_item.roll_neg),
        .o_sin   (s_phi),
        .o_cos   (c_phi)
    );

    bre_cordic u_cordic_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_item.pitch_a),
        .i_neg   (i_item.pitch_neg),
        .o_sin   (s_th),
        .o_cos   (c_th)
    );

    // rates follow the CORDIC latency
    for (genvar k = 0; k < CL; k++) begin : g_d1
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v1[k] <= 1'b0;
            end else if (en) begin
                r_v1[k] <= (k == 0) ? o_pop : r_v1[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_p1[k] <= (k == 0) ? i_item.p : r_p1[(k == 0) ? 0 : k-1];
                r_q1[k] <= (k == 0) ? i_item.q : r_q1[(k == 0) ? 0 : k-1];
                r_r1[k] <= (k == 0) ? i_item.r : r_r1[(k == 0) ? 0 : k-1];
            end
        end
    end

    // magnitudes and rounding terms
    assign abs_v    = r_v[34] ? 35'(-r_v) : 35'(r_v);
    assign pr_mag   = 19'((36'(abs_v) + 36'd32768) >> 16);
    assign abs_c    = r_m3_c[SW-1] ? SW'(-r_m3_c) : SW'(r_m3_c);
    assign abs_w    = r_m3_w[34] ? 35'(-r_m3_w) : 35'(r_m3_w);
    assign abs_prod = r_prod[52] ? 53'(-r_prod) : 53'(r_prod);
    assign rsum     = 54'(abs_prod) + (54'(abs_c) << 15);

    always_comb begin
        m4_sd.p        = r_m3_p;
        m4_sd.pitch    = r_m3_pitch;
        m4_sd.w_zero   = (r_m3_w == '0);
        m4_sd.pos      = (r_m3_w[34] == r_m3_c[SW-1]);
        m4_sd.s_neg    = r_m3_s[SW-1];
        m4_sd.sing     = (r_m3_c < bre_pkg::COS_MIN) && (r_m3_c > -bre_pkg::COS_MIN);
        m4_sd.yaw_neg  = r_m3_w[34] ^ r_m3_c[SW-1];
        m4_sd.roll_neg = r_prod[52] ^ r_m3_c[SW-1];
    end

    // product, sum and rounding stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_m3_v <= 1'b0;
            r_m4_v <= 1'b0;
        end else if (en) begin
            r_m1_v <= r_v1[CL-1];
            r_m2_v <= r_m1_v;
            r_m3_v <= r_m2_v;
            r_m4_v <= r_m3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq   <= s_phi * r_q1[CL-1];
            r_cr   <= c_phi * r_r1[CL-1];
            r_cq   <= c_phi * r_q1[CL-1];
            r_sr   <= s_phi * r_r1[CL-1];
            r_m1_p <= r_p1[CL-1];
            r_m1_s <= s_th;
            r_m1_c <= c_th;

            r_w    <= 35'(r_sq) + 35'(r_cr);
            r_v    <= 35'(r_cq) - 35'(r_sr);
            r_m2_p <= r_m1_p;
            r_m2_s <= r_m1_s;
            r_m2_c <= r_m1_c;

            r_prod     <= r_w * r_m2_s;
            r_m3_pitch <= r_v[34] ? -bre_pkg::OUT_W'(pr_mag) : bre_pkg::OUT_W'(pr_mag);
            r_m3_w     <= r_w;
            r_m3_p     <= r_m2_p;
            r_m3_s     <= r_m2_s;
            r_m3_c     <= r_m2_c;

            r_ynum  <= 35'(abs_w) + 35'(abs_c >> 1);
            r_rnum  <= 35'(rsum >> 16);
            r_den   <= abs_c;
            r_m4_sd <= m4_sd;
        end
    end

    bre_div u_div_yaw (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_ynum),
        .i_den (r_den),
        .o_quo (q_yaw)
    );

    bre_div u_div_roll (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_rnum),
        .i_den (r_den),
        .o_quo (q_roll)
    );

    // side fields follow the divider latency
    for (genvar k = 0; k < DL; k++) begin : g_d2
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v2[k] <= 1'b0;
            end else if (en) begin
                r_v2[k] <= (k == 0) ? r_m4_v : r_v2[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sd[k] <= (k == 0) ? r_m4_sd : r_sd[(k == 0) ? 0 : k-1];
            end
        end
    end

    // sign, sum, saturation and the near-vertical pitch case
    assign sd        = r_sd[DL-1];
    assign yaw_full  = sd.yaw_neg ? -$signed({3'b0, q_yaw}) : $signed({3'b0, q_yaw});
    assign tan_full  = sd.roll_neg ? -$signed({3'b0, q_roll}) : $signed({3'b0, q_roll});
    assign roll_full = 30'(sd.p) + tan_full;
    assign yaw_sat   = bre_pkg::sat24(yaw_full);
    assign roll_sat  = bre_pkg::sat24(roll_full);

    always_comb begin
        if (sd.sing) begin
            n_flag = 1'b1;
            if (sd.w_zero) begin
                n_yaw  = '0;
                n_roll = bre_pkg::OUT_W'(sd.p);
            end else begin
                n_yaw  = sd.pos ? bre_pkg::OUT_MAX : bre_pkg::OUT_MIN;
                n_roll = (sd.pos ^ sd.s_neg) ? bre_pkg::OUT_MAX : bre_pkg::OUT_MIN;
            end
        end else begin
            n_flag = yaw_sat[bre_pkg::OUT_W] | roll_sat[bre_pkg::OUT_W];
            n_yaw  = yaw_sat[bre_pkg::OUT_W-1:0];
            n_roll = roll_sat[bre_pkg::OUT_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_v2[DL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll_rate  <= n_roll;
            r_pitch_rate <= sd.pitch;
            r_yaw_rate   <= n_yaw;
            r_singular   <= n_flag;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_roll_rate  = r_roll_rate;
    assign o_pitch_rate = r_pitch_rate;
    assign o_yaw_rate   = r_yaw_rate;
    assign o_singular   = r_singular;

endmodule

// ===== hw/rtl/body_rates_to_euler_rates.sv =====
// channel  | handshake          | payload
// ---------+--------------------+--------------------------------------------------
// input    | i_valid / o_ready  | i_roll_angle, i_pitch_angle, i_rate_x/y/z
// output   | o_valid / i_ready  | o_roll_rate, o_pitch_rate, o_yaw_rate, o_singular
//
// One item per cycle sustained unless the output is held. Path: queue, 25 CORDIC
// stages, 4 multiply/round stages, 27 divider stages and the output register.
// Reset clears the queue pointers and all valid bits; no clearing pass.
// A held output register stalls the whole back pipeline; the queue keeps taking
// input until it fills.
module body_rates_to_euler_rates #(
    parameter int QDEPTH = bre_pkg::QDEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [bre_pkg::ANG_W-1:0]  i_roll_angle,
    input  logic signed [bre_pkg::ANG_W-1:0]  i_pitch_angle,
    input  logic signed [bre_pkg::RATE_W-1:0] i_rate_x,
    input  logic signed [bre_pkg::RATE_W-1:0] i_rate_y,
    input  logic signed [bre_pkg::RATE_W-1:0] i_rate_z,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [bre_pkg::OUT_W-1:0]  o_roll_rate,
    output logic signed [bre_pkg::OUT_W-1:0]  o_pitch_rate,
    output logic signed [bre_pkg::OUT_W-1:0]  o_yaw_rate,
    output logic                              o_singular
);

    bre_pkg::t_qstat qstat;
    bre_pkg::t_item  push_item;
    bre_pkg::t_item  head_item;
    logic            push;
    logic            pop;

    bre_front u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_roll_angle  (i_roll_angle),
        .i_pitch_angle (i_pitch_angle),
        .i_rate_x      (i_rate_x),
        .i_rate_y      (i_rate_y),
        .i_rate_z      (i_rate_z),
        .i_qstat       (qstat),
        .o_push        (push),
        .o_item        (push_item)
    );

    bre_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_qstat (qstat)
    );

    bre_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (head_item),
        .i_qstat      (qstat),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_roll_rate  (o_roll_rate),
        .o_pitch_rate (o_pitch_rate),
        .o_yaw_rate   (o_yaw_rate),
        .o_singular   (o_singular)
    );

    // an accepted transfer leaves the queue non-empty
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !qstat.empty)
        else $error("queue empty after a transfer in");

    // never pop an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

    // pitch rate is bounded well inside 24 bits
    a_pitch_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_rate < 24'sd524288) && (o_pitch_rate > -24'sd524288))
        else $error("pitch rate out of range");

endmodule
